@@ hdl/sstd_pkg.sv @@
package sstd_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned MAX_TICKS   = 160;
  localparam int unsigned MIN_TICKS   = 2;
  localparam int unsigned TICK_W      = 8;

  localparam int unsigned SPAN   = (MAX_TICKS > MIN_TICKS) ? (MAX_TICKS - MIN_TICKS) : 0;
  localparam int unsigned SPAN_W = ($clog2(SPAN + 1) < 2) ? 2 : $clog2(SPAN + 1);
  localparam int unsigned NUM_W  = SAMPLE_BITS + SPAN_W;
  localparam int unsigned CNT_W  = $clog2(SPAN_W);

  typedef enum logic [1:0] {
    FUNC_CAL  = 2'd0,
    FUNC_PLAY = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

@@ hdl/sstd_div.sv @@
module sstd_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [sstd_pkg::NUM_W-1:0]            num_i,
  input  logic [sstd_pkg::SAMPLE_BITS-1:0]      den_i,
  output logic                                  done_o,
  output logic [sstd_pkg::SPAN_W-1:0]           quot_o
);

  logic [sstd_pkg::SAMPLE_BITS-1:0] rem_q, rem_d;
  logic [sstd_pkg::SPAN_W-1:0]      qsh_q, qsh_d;
  logic [sstd_pkg::CNT_W-1:0]       cnt_q;
  logic                             busy_q;
  logic [sstd_pkg::SAMPLE_BITS:0]   trial;
  logic [sstd_pkg::SAMPLE_BITS:0]   diff;
  logic                             ge;

  assign trial  = {rem_q, qsh_q[sstd_pkg::SPAN_W-1]};
  assign ge     = trial >= {1'b0, den_i};
  assign diff   = trial - {1'b0, den_i};
  assign rem_d  = ge ? diff[sstd_pkg::SAMPLE_BITS-1:0] : trial[sstd_pkg::SAMPLE_BITS-1:0];
  assign qsh_d  = {qsh_q[sstd_pkg::SPAN_W-2:0], ge};
  assign done_o = busy_q && (cnt_q == sstd_pkg::CNT_W'(sstd_pkg::SPAN_W - 1));
  assign quot_o = qsh_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[sstd_pkg::NUM_W-1:sstd_pkg::SPAN_W];
      qsh_q <= num_i[sstd_pkg::SPAN_W-1:0];
    end else if (busy_q) begin
      rem_q <= rem_d;
      qsh_q <= qsh_d;
    end
  end

endmodule

@@ hdl/sensor_scaled_tone_divider_unit.sv @@
// Sensor-scaled tone divider.
// Input channel (in_valid_i/in_ready_o) carries one word: func_i and sample_i.
//   Calibration words widen the stored sensor range, play words rescale the
//   reading to an even tone period, tick words advance the tone counter.
// Output channel (out_valid_o/out_ready_i) returns one word per input word:
//   tone level, period count and the calibrated range after that word.
// Sequence: calibration, tick and unused codes go from accept straight to the
//   done state, which loads the output register; a play word with a valid range
//   passes a multiply state, 8 steps of the restoring divider and then the done
//   state; a play word with an empty range goes straight to the done state.
// Throughput: one word at a time; in_ready_o is high only while the sequencer
//   is idle, so a new word is taken only once the last has left the done state.
// A finished result sits in the output register; the next word is accepted
//   and processed meanwhile, and waits in the done state while the receiver
//   stalls.
// Reset: range low is all ones, range high 0, period count 1, tick counter 0,
//   tone level low, no result pending.
module sensor_scaled_tone_divider_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            func_i,
  input  logic [sstd_pkg::SAMPLE_BITS-1:0]      sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  tone_level_o,
  output logic [sstd_pkg::TICK_W-1:0]           period_count_o,
  output logic [sstd_pkg::SAMPLE_BITS-1:0]      range_low_o,
  output logic [sstd_pkg::SAMPLE_BITS-1:0]      range_high_o
);

  sstd_pkg::state_e state_q, state_d;

  logic [sstd_pkg::SAMPLE_BITS-1:0] min_q, min_d;
  logic [sstd_pkg::SAMPLE_BITS-1:0] max_q, max_d;
  logic [sstd_pkg::TICK_W-1:0]      target_q, target_d;
  logic [sstd_pkg::TICK_W-1:0]      tick_q, tick_d;
  logic                             pin_q, pin_d;
  logic [sstd_pkg::SAMPLE_BITS-1:0] off_q, off_d;
  logic [sstd_pkg::SAMPLE_BITS-1:0] den_q, den_d;

  logic                             out_valid_q, out_valid_d;
  logic                             out_pin_q;
  logic [sstd_pkg::TICK_W-1:0]      out_target_q;
  logic [sstd_pkg::SAMPLE_BITS-1:0] out_min_q, out_max_q;

  logic                             accept;
  logic                             out_load;
  logic                             div_start;
  logic                             div_done;
  logic [sstd_pkg::SPAN_W-1:0]      quot;
  logic [sstd_pkg::NUM_W-1:0]       product;
  logic                             empty;
  logic [sstd_pkg::SAMPLE_BITS-1:0] x_cl;
  logic [sstd_pkg::TICK_W:0]        tick_inc;
  logic                             wrap;
  logic [sstd_pkg::TICK_W:0]        t_sum;
  logic [sstd_pkg::TICK_W-1:0]      t_even;

  assign empty   = max_q <= min_q;
  assign x_cl    = (sample_i > max_q) ? max_q : ((sample_i < min_q) ? min_q : sample_i);
  assign product = sstd_pkg::NUM_W'(off_q) * sstd_pkg::NUM_W'(sstd_pkg::SPAN);
  assign tick_inc = {1'b0, tick_q} + 1'b1;
  assign wrap     = tick_inc >= {1'b0, target_q};
  assign t_sum    = (sstd_pkg::TICK_W + 1)'(quot) + (sstd_pkg::TICK_W + 1)'(sstd_pkg::MIN_TICKS);
  assign t_even   = {t_sum[sstd_pkg::TICK_W-1:1], 1'b0};

  sstd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (product),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      sstd_pkg::ST_IDLE: begin
        if (accept) begin
          if (func_i == sstd_pkg::FUNC_PLAY && !empty) begin
            state_d = sstd_pkg::ST_MUL;
          end else begin
            state_d = sstd_pkg::ST_DONE;
          end
        end
      end
      sstd_pkg::ST_MUL: begin
        state_d = sstd_pkg::ST_DIV;
      end
      sstd_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = sstd_pkg::ST_DONE;
        end
      end
      sstd_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = sstd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sstd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == sstd_pkg::ST_IDLE;
    accept      = in_valid_i && in_ready_o;
    div_start   = state_q == sstd_pkg::ST_MUL;
    out_load    = (state_q == sstd_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
    out_valid_d = out_load || (out_valid_q && !out_ready_i);

    min_d    = min_q;
    max_d    = max_q;
    target_d = target_q;
    tick_d   = tick_q;
    pin_d    = pin_q;
    off_d    = off_q;
    den_d    = den_q;

    if (accept) begin
      case (func_i)
        sstd_pkg::FUNC_CAL: begin
          if (sample_i > max_q) begin
            max_d = sample_i;
          end
          if (sample_i < min_q) begin
            min_d = sample_i;
          end
        end
        sstd_pkg::FUNC_PLAY: begin
          off_d = x_cl - min_q;
          den_d = max_q - min_q;
          if (empty) begin
            target_d = sstd_pkg::TICK_W'(sstd_pkg::MIN_TICKS & ~1);
          end
        end
        sstd_pkg::FUNC_TICK: begin
          if (wrap) begin
            tick_d = '0;
            pin_d  = 1'b0;
          end else begin
            tick_d = tick_inc[sstd_pkg::TICK_W-1:0];
            if (tick_inc[sstd_pkg::TICK_W-1:0] == (target_q >> 1)) begin
              pin_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (state_q == sstd_pkg::ST_DIV && div_done) begin
      target_d = t_even;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sstd_pkg::ST_IDLE;
      min_q       <= '1;
      max_q       <= '0;
      target_q    <= sstd_pkg::TICK_W'(1);
      tick_q      <= '0;
      pin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_q       <= min_d;
      max_q       <= max_d;
      target_q    <= target_d;
      tick_q      <= tick_d;
      pin_q       <= pin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    den_q <= den_d;
    if (out_load) begin
      out_pin_q    <= pin_q;
      out_target_q <= target_q;
      out_min_q    <= min_q;
      out_max_q    <= max_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tone_level_o   = out_pin_q;
  assign period_count_o = out_target_q;
  assign range_low_o    = out_min_q;
  assign range_high_o   = out_max_q;

`ifndef SYNTHESIS
  a_play_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i == sstd_pkg::FUNC_PLAY && !empty |=> state_q == sstd_pkg::ST_MUL)
    else $error("play word with valid range did not start multiply");

  a_mul_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sstd_pkg::ST_MUL |=> state_q == sstd_pkg::ST_DIV)
    else $error("multiply did not hand over to divider");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == sstd_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_target_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    target_q[0] == 1'b0 || target_q == sstd_pkg::TICK_W'(1))
    else $error("period count is odd");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_ready_i)
    else $error("result overwritten while pending");
`endif

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT = 200000;

  typedef struct packed {
    logic                             tone;
    logic [sstd_pkg::TICK_W-1:0]      period;
    logic [sstd_pkg::SAMPLE_BITS-1:0] lo;
    logic [sstd_pkg::SAMPLE_BITS-1:0] hi;
  } tone_word_t;

  typedef struct {
    sstd_pkg::func_e                  f;
    logic [sstd_pkg::SAMPLE_BITS-1:0] s;
    bit                               fixed;
    tone_word_t                       want;
  } dir_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [1:0]                       func_i;
  logic [sstd_pkg::SAMPLE_BITS-1:0] sample_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic                             tone_level_o;
  logic [sstd_pkg::TICK_W-1:0]      period_count_o;
  logic [sstd_pkg::SAMPLE_BITS-1:0] range_low_o;
  logic [sstd_pkg::SAMPLE_BITS-1:0] range_high_o;

  logic [sstd_pkg::SAMPLE_BITS-1:0] rng_lo;
  logic [sstd_pkg::SAMPLE_BITS-1:0] rng_hi;
  logic [sstd_pkg::TICK_W-1:0]      period_q;
  logic [sstd_pkg::TICK_W-1:0]      tick_q;
  logic                             tone_q;

  tone_word_t tone_exp_q[$];
  tone_word_t got_w;
  tone_word_t want_w;
  dir_row_t   dir_q[$];

  int  errors   = 0;
  int  cycles   = 0;
  int  accepted = 0;
  bit  quiet    = 1'b0;
  bit  held     = 1'b0;

  sensor_scaled_tone_divider_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tone_level_o   (tone_level_o),
    .period_count_o (period_count_o),
    .range_low_o    (range_low_o),
    .range_high_o   (range_high_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [sstd_pkg::TICK_W-1:0] scale_period(
      logic [sstd_pkg::SAMPLE_BITS-1:0] s);
    int unsigned x;
    int unsigned t;
    if (rng_hi <= rng_lo) return sstd_pkg::TICK_W'(sstd_pkg::MIN_TICKS & ~1);
    x = s;
    if (x > rng_hi) x = rng_hi;
    else if (x < rng_lo) x = rng_lo;
    t = (x - rng_lo) * sstd_pkg::SPAN / (rng_hi - rng_lo) + sstd_pkg::MIN_TICKS;
    return sstd_pkg::TICK_W'(t & ~32'd1);
  endfunction

  function automatic tone_word_t tone_step(sstd_pkg::func_e f,
                                           logic [sstd_pkg::SAMPLE_BITS-1:0] s);
    tone_word_t  w;
    int unsigned c;
    case (f)
      sstd_pkg::FUNC_CAL: begin
        if (s > rng_hi) rng_hi = s;
        if (s < rng_lo) rng_lo = s;
      end
      sstd_pkg::FUNC_PLAY: period_q = scale_period(s);
      sstd_pkg::FUNC_TICK: begin
        c = tick_q + 1;
        if (c >= period_q) c = 0;
        tick_q = sstd_pkg::TICK_W'(c);
        if (tick_q == 0) tone_q = 1'b0;
        else if (tick_q == period_q / 2) tone_q = 1'b1;
      end
      default: ;
    endcase
    w.tone   = tone_q;
    w.period = period_q;
    w.lo     = rng_lo;
    w.hi     = rng_hi;
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
  endtask

  task automatic add_row(sstd_pkg::func_e f, int s, bit fixed = 1'b0, int tone = 0,
                         int per = 0, int lo = 0, int hi = 0);
    dir_row_t r;
    r.f           = f;
    r.s           = sstd_pkg::SAMPLE_BITS'(s);
    r.fixed       = fixed;
    r.want.tone   = tone[0];
    r.want.period = sstd_pkg::TICK_W'(per);
    r.want.lo     = sstd_pkg::SAMPLE_BITS'(lo);
    r.want.hi     = sstd_pkg::SAMPLE_BITS'(hi);
    dir_q.push_back(r);
  endtask

  task automatic send_word(sstd_pkg::func_e f, logic [sstd_pkg::SAMPLE_BITS-1:0] s,
                           bit fixed = 1'b0, tone_word_t want = '0);
    tone_word_t pred;
    int         gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    pred = tone_step(f, s);
    tone_exp_q.push_back(fixed ? want : pred);
    accepted++;
  endtask

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_w = '{tone_level_o, period_count_o, range_low_o, range_high_o};
      if (tone_exp_q.size() == 0) begin
        report_mismatch("unexpected word, period", got_w.period, 0);
      end else begin
        want_w = tone_exp_q.pop_front();
        if (got_w.tone !== want_w.tone)
          report_mismatch("tone_level", got_w.tone, want_w.tone);
        if (got_w.period !== want_w.period)
          report_mismatch("period_count", got_w.period, want_w.period);
        if (got_w.lo !== want_w.lo)
          report_mismatch("range_low", got_w.lo, want_w.lo);
        if (got_w.hi !== want_w.hi)
          report_mismatch("range_high", got_w.hi, want_w.hi);
      end
    end
  end

  // receiver: random stalls, one long hold-off to back up the input
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && accepted >= 120) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (80) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    int k;
    int v;
    int nt;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = sstd_pkg::FUNC_NONE;
    sample_i   = '0;
    rng_lo     = '1;
    rng_hi     = '0;
    period_q   = 1;
    tick_q     = 0;
    tone_q     = 1'b0;

    add_row(sstd_pkg::FUNC_NONE, 1023, 1, 0, 1, 1023, 0);
    add_row(sstd_pkg::FUNC_TICK, 0,    1, 0, 1, 1023, 0);
    add_row(sstd_pkg::FUNC_PLAY, 512,  1, 0, 2, 1023, 0);
    add_row(sstd_pkg::FUNC_TICK, 1023, 1, 1, 2, 1023, 0);
    add_row(sstd_pkg::FUNC_TICK, 0,    1, 0, 2, 1023, 0);
    add_row(sstd_pkg::FUNC_CAL,  500,  1, 0, 2, 500, 500);
    add_row(sstd_pkg::FUNC_PLAY, 500,  1, 0, 2, 500, 500);
    add_row(sstd_pkg::FUNC_CAL,  300,  1, 0, 2, 300, 500);
    add_row(sstd_pkg::FUNC_CAL,  700,  1, 0, 2, 300, 700);
    add_row(sstd_pkg::FUNC_PLAY, 0,    1, 0, 2, 300, 700);
    add_row(sstd_pkg::FUNC_PLAY, 1023, 1, 0, 160, 300, 700);
    add_row(sstd_pkg::FUNC_PLAY, 501);
    add_row(sstd_pkg::FUNC_PLAY, 303);
    repeat (2) add_row(sstd_pkg::FUNC_TICK, 341);
    add_row(sstd_pkg::FUNC_PLAY, 310);
    repeat (5) add_row(sstd_pkg::FUNC_TICK, 682);
    add_row(sstd_pkg::FUNC_PLAY, 305);
    add_row(sstd_pkg::FUNC_TICK, 0);
    add_row(sstd_pkg::FUNC_NONE, 0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_q[i]) send_word(dir_q[i].f, dir_q[i].s, dir_q[i].fixed, dir_q[i].want);

    n = 0;
    while (n < 410) begin
      if (n >= 360) quiet = 1'b1;
      k = $urandom_range(0, 99);
      if (k < 10) begin
        case ($urandom_range(0, 2))
          0: begin
            v = int'(rng_lo) - int'($urandom_range(0, 24));
            if (v < 0) v = 0;
          end
          1: begin
            v = int'(rng_hi) + int'($urandom_range(0, 24));
            if (v > 1023) v = 1023;
          end
          default: v = $urandom_range(rng_lo, rng_hi);
        endcase
        send_word(sstd_pkg::FUNC_CAL, sstd_pkg::SAMPLE_BITS'(v));
        n++;
      end else if (k < 14) begin
        send_word(sstd_pkg::FUNC_NONE, sstd_pkg::SAMPLE_BITS'($urandom_range(0, 1023)));
        n++;
      end else if (k < 40) begin
        if ($urandom_range(0, 1))
          v = $urandom_range(0, 1023);
        else
          v = int'(rng_lo) + int'($urandom_range(0, (int'(rng_hi) - int'(rng_lo)) / 6));
        send_word(sstd_pkg::FUNC_PLAY, sstd_pkg::SAMPLE_BITS'(v));
        nt = $urandom_range(1, 48);
        for (int j = 0; j < nt; j++)
          send_word(sstd_pkg::FUNC_TICK, sstd_pkg::SAMPLE_BITS'($urandom_range(0, 1023)));
        n += nt + 1;
      end else begin
        send_word(sstd_pkg::FUNC_TICK, sstd_pkg::SAMPLE_BITS'($urandom_range(0, 1023)));
        n++;
      end
    end

    send_word(sstd_pkg::FUNC_CAL, 0);
    send_word(sstd_pkg::FUNC_CAL, 1023);
    send_word(sstd_pkg::FUNC_PLAY, 0);
    send_word(sstd_pkg::FUNC_PLAY, 1023);
    send_word(sstd_pkg::FUNC_PLAY, sstd_pkg::SAMPLE_BITS'($urandom_range(0, 40)));
    repeat (12)
      send_word(sstd_pkg::FUNC_TICK, sstd_pkg::SAMPLE_BITS'($urandom_range(0, 1023)));
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (tone_exp_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
